>>> rtl/sdf_pkg.sv
// Shared types, constants and the CRC-16 byte update for the sync-word packet deframer.
// No dependencies; used by sdf_parse, the top level and the testbench.
package sdf_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned OUT_DATA_W = 64;

  localparam logic [WORD_W-1:0] SYNC_WORD_RST = 16'h5555;
  localparam logic [WORD_W-1:0] CRC_SEED_RST  = 16'h1D0F;
  localparam logic [WORD_W-1:0] CRC_POLY      = 16'h1021;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_SEED  = 4'd1;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  typedef enum logic [7:0] {
    PH_SYNC_HI = 8'b0000_0001,
    PH_SYNC_LO = 8'b0000_0010,
    PH_TYPE_HI = 8'b0000_0100,
    PH_TYPE_LO = 8'b0000_1000,
    PH_LENGTH  = 8'b0001_0000,
    PH_PAYLOAD = 8'b0010_0000,
    PH_CRC_HI  = 8'b0100_0000,
    PH_CRC_LO  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic              crc_good;
    logic [WORD_W-1:0] received_crc;
    logic [BYTE_W-1:0] payload_length;
    logic [WORD_W-1:0] pkt_type;
    logic [BYTE_W-1:0] byte_index;
    logic [BYTE_W-1:0] payload_byte;
    logic              result_kind;
  } res_t;

  localparam int unsigned RES_W = $bits(res_t);

  // CRC-16, MSB first, one byte folded in over eight bit steps
  function automatic logic [WORD_W-1:0] crc_feed(input logic [WORD_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[WORD_W-1]) begin
        c = {c[WORD_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[WORD_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/sdf_stage.sv
// One pipeline register stage with valid/ready handshake on both sides.
// No dependencies.
module sdf_stage #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [WIDTH-1:0] up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output logic [WIDTH-1:0] dn_data
);

  logic             valid_r;
  logic             valid_nxt;
  logic [WIDTH-1:0] data_r;

  // Load whenever the slot is empty or is being emptied this cycle
  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= up_data;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

>>> rtl/sdf_parse.sv
// Frame parser: sync hunt, header capture, running CRC and result build.
// Depends on sdf_pkg (phase encoding, result struct, crc_feed).
module sdf_parse (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [sdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sdf_pkg::WORD_W-1:0]    cfg_data,
  input  logic                          fire,
  input  logic [sdf_pkg::BYTE_W-1:0]    rx_byte,
  output logic                          res_valid,
  output sdf_pkg::res_t                 res
);

  logic [sdf_pkg::WORD_W-1:0] sync_word_r;
  logic [sdf_pkg::WORD_W-1:0] crc_seed_r;

  sdf_pkg::phase_t            phase_r, phase_nxt;
  logic [sdf_pkg::WORD_W-1:0] crc_r, crc_nxt;
  logic [sdf_pkg::WORD_W-1:0] type_r, type_nxt;
  logic [sdf_pkg::BYTE_W-1:0] len_r, len_nxt;
  logic [sdf_pkg::BYTE_W-1:0] count_r, count_nxt;
  logic [sdf_pkg::BYTE_W-1:0] crc_hi_r, crc_hi_nxt;

  logic [sdf_pkg::WORD_W-1:0] crc_fed;
  logic [sdf_pkg::WORD_W-1:0] rx_crc;
  logic [sdf_pkg::BYTE_W-1:0] count_inc;
  logic [sdf_pkg::BYTE_W-1:0] sync_hi;
  logic [sdf_pkg::BYTE_W-1:0] sync_lo;

  assign sync_hi   = sync_word_r[sdf_pkg::WORD_W-1:sdf_pkg::BYTE_W];
  assign sync_lo   = sync_word_r[sdf_pkg::BYTE_W-1:0];
  assign crc_fed   = sdf_pkg::crc_feed(crc_r, rx_byte);
  assign rx_crc    = {crc_hi_r, rx_byte};
  assign count_inc = count_r + 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r <= sdf_pkg::SYNC_WORD_RST;
      crc_seed_r  <= sdf_pkg::CRC_SEED_RST;
    end else if (cfg_valid) begin
      if (cfg_index == sdf_pkg::REG_SYNC_WORD) begin
        sync_word_r <= cfg_data;
      end else if (cfg_index == sdf_pkg::REG_CRC_SEED) begin
        crc_seed_r <= cfg_data;
      end
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    crc_nxt    = crc_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    count_nxt  = count_r;
    crc_hi_nxt = crc_hi_r;
    res_valid  = 1'b0;
    res        = '0;
    res.pkt_type       = type_r;
    res.payload_length = len_r;
    unique case (phase_r)
      sdf_pkg::PH_SYNC_HI: begin
        if (rx_byte == sync_hi) phase_nxt = sdf_pkg::PH_SYNC_LO;
      end
      sdf_pkg::PH_SYNC_LO: begin
        if (rx_byte == sync_lo) begin
          phase_nxt = sdf_pkg::PH_TYPE_HI;
          crc_nxt   = crc_seed_r;
        end else if (rx_byte != sync_hi) begin
          phase_nxt = sdf_pkg::PH_SYNC_HI;
        end
      end
      sdf_pkg::PH_TYPE_HI: begin
        type_nxt  = {rx_byte, 8'h00};
        crc_nxt   = crc_fed;
        phase_nxt = sdf_pkg::PH_TYPE_LO;
      end
      sdf_pkg::PH_TYPE_LO: begin
        type_nxt  = {type_r[sdf_pkg::WORD_W-1:sdf_pkg::BYTE_W], rx_byte};
        crc_nxt   = crc_fed;
        phase_nxt = sdf_pkg::PH_LENGTH;
      end
      sdf_pkg::PH_LENGTH: begin
        len_nxt   = rx_byte;
        count_nxt = '0;
        crc_nxt   = crc_fed;
        phase_nxt = (rx_byte == 8'd0) ? sdf_pkg::PH_CRC_HI : sdf_pkg::PH_PAYLOAD;
      end
      sdf_pkg::PH_PAYLOAD: begin
        crc_nxt          = crc_fed;
        res_valid        = 1'b1;
        res.result_kind  = sdf_pkg::KIND_PAYLOAD;
        res.payload_byte = rx_byte;
        res.byte_index   = count_r;
        count_nxt        = count_inc;
        if (count_inc >= len_r) phase_nxt = sdf_pkg::PH_CRC_HI;
      end
      sdf_pkg::PH_CRC_HI: begin
        crc_hi_nxt = rx_byte;
        phase_nxt  = sdf_pkg::PH_CRC_LO;
      end
      sdf_pkg::PH_CRC_LO: begin
        res_valid        = 1'b1;
        res.result_kind  = sdf_pkg::KIND_END;
        res.received_crc = rx_crc;
        res.crc_good     = (rx_crc == crc_r);
        phase_nxt        = sdf_pkg::PH_SYNC_HI;
      end
      default: begin
        phase_nxt = sdf_pkg::PH_SYNC_HI;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sdf_pkg::PH_SYNC_HI;
      crc_r   <= sdf_pkg::CRC_SEED_RST;
    end else if (fire) begin
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
    end
  end

  // Header fields and counters are always written before they are read
  always_ff @(posedge clk) begin
    if (fire) begin
      type_r   <= type_nxt;
      len_r    <= len_nxt;
      count_r  <= count_nxt;
      crc_hi_r <= crc_hi_nxt;
    end
  end

endmodule

>>> rtl/sync_crc16_packet_deframer_unit.sv
// Top level of the sync-word CRC-16 packet deframer.
// Depends on sdf_pkg, sdf_stage and sdf_parse.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+------------------------------------------
//  in_     | slave     | in_tvalid/in_tready  | in_tdata[7:0] rx_byte
//  out_    | master    | out_tvalid/out_tready| out_tuser result_kind, out_tdata packed
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index register, cfg_data value
//
// Each byte waits in the input register and is parsed in the cycle it leaves; its
// result, if any, lands in the output register. One byte per cycle is sustained
// while out_tready stays high; the parser's combinational CRC byte update sets that
// figure. Reset (rst_n low, synchronous) empties both registers, returns the parser
// to the sync hunt and reloads the register defaults. A stalled output holds its
// item and backs pressure up through the input register.
module sync_crc16_packet_deframer_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // slave stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sdf_pkg::BYTE_W-1:0]          in_tdata,   // [7:0] rx_byte
  // master stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sdf_pkg::OUT_DATA_W-1:0]      out_tdata,  // [7:0] payload_byte,
                                                          // [15:8] byte_index,
                                                          // [31:16] pkt_type,
                                                          // [39:32] payload_length,
                                                          // [55:40] received_crc,
                                                          // [56] crc_good, [63:57] zero
  output logic [0:0]                          out_tuser,  // [0] result_kind
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sdf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sdf_pkg::WORD_W-1:0]          cfg_data
);

  logic                       s1_valid;
  logic [sdf_pkg::BYTE_W-1:0] s1_byte;
  logic                       out_slot_ready;
  logic                       fire;
  logic                       res_valid;
  sdf_pkg::res_t              res;
  logic [sdf_pkg::RES_W-1:0]  res_q;
  sdf_pkg::res_t              res_out;

  // Registers are always writable; the user must make writes only while the block is idle (unchecked)
  assign cfg_ready = 1'b1;

  // Input register: holds the byte waiting for the parser
  sdf_stage #(
    .WIDTH (sdf_pkg::BYTE_W)
  ) u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (in_tdata),
    .dn_valid (s1_valid),
    .dn_ready (out_slot_ready),
    .dn_data  (s1_byte)
  );

  // Parse a byte only when the output register can take whatever it produces
  assign fire = s1_valid && out_slot_ready;

  sdf_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .rx_byte   (s1_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register: bytes that make no result just pass through the parser
  sdf_stage #(
    .WIDTH (sdf_pkg::RES_W)
  ) u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid && res_valid),
    .up_ready (out_slot_ready),
    .up_data  (res),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (res_q)
  );

  assign res_out = sdf_pkg::res_t'(res_q);

  assign out_tuser = res_out.result_kind;
  assign out_tdata = {7'd0,
                      res_out.crc_good,
                      res_out.received_crc,
                      res_out.payload_length,
                      res_out.pkt_type,
                      res_out.byte_index,
                      res_out.payload_byte};

endmodule

>>> verif/tb_sync_crc16_packet_deframer_unit.sv
// Self-checking testbench for sync_crc16_packet_deframer_unit: byte stream in, payload
// and packet-end items out, checked against an in-bench model of the deframer.
// Depends on sdf_pkg and the RTL of the block; needs nothing else.
module tb_sync_crc16_packet_deframer_unit;
  import sdf_pkg::*;

  typedef logic [BYTE_W-1:0]    octet_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Longest stretch with no handshake on any channel before the run is declared hung
  localparam int unsigned QUIET_LIMIT   = 2000;
  // Cycles to let the pipeline empty after the last result (input and output registers)
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam cfg_idx_t    REG_FIRST_UNUSED = cfg_idx_t'(REG_CRC_SEED + 1);

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata   = '0;   // [7:0] rx_byte
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [7:0] payload_byte, [15:8] byte_index,
                                            // [31:16] pkt_type, [39:32] payload_length,
                                            // [55:40] received_crc, [56] crc_good
  logic [0:0]            out_tuser;         // [0] result_kind
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [WORD_W-1:0]     cfg_data   = '0;

  sync_crc16_packet_deframer_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Register values as the block should hold them; written only while it is idle
  logic [WORD_W-1:0] sync_cfg = SYNC_WORD_RST;
  logic [WORD_W-1:0] seed_cfg = CRC_SEED_RST;

  // Deframer state as predicted
  phase_t            ps_phase   = PH_SYNC_HI;
  logic [WORD_W-1:0] ps_crc     = CRC_SEED_RST;
  logic [WORD_W-1:0] ps_type    = '0;
  logic [BYTE_W-1:0] ps_length  = '0;
  logic [BYTE_W-1:0] ps_count   = '0;
  logic [BYTE_W-1:0] ps_crc_hi  = '0;

  octet_t      rx_bytes_q[$];     // bytes waiting for the sender
  res_t        due_results[$];    // predicted items not yet seen on the output
  int unsigned bytes_shown  = 0;  // items put on in_tdata
  int unsigned bytes_taken  = 0;  // items accepted by the block
  int unsigned in_gap_left  = 0;
  int unsigned out_stall_left = 0;
  bit          in_gaps_on   = 1'b0;
  bit          out_stalls_on = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned errors       = 0;

  // CRC-16 (0x1021, MSB first), one message bit at a time
  function automatic logic [WORD_W-1:0] crc16_byte(input logic [WORD_W-1:0] crc,
                                                   input octet_t b);
    logic [WORD_W-1:0] c;
    logic              fb;
    c = crc;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb = c[WORD_W-1] ^ b[i];
      c  = {c[WORD_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    end
    return c;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_idle(input bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 24);
  endfunction

  // Advance the predicted deframer by one byte; queue the item it should emit
  task automatic deframe_byte(input octet_t b);
    res_t r;
    r = '0;
    case (ps_phase)
      PH_SYNC_HI: begin
        if (b == sync_cfg[15:8]) ps_phase = PH_SYNC_LO;
      end
      PH_SYNC_LO: begin
        if (b == sync_cfg[7:0]) begin
          ps_phase = PH_TYPE_HI;
          ps_crc   = seed_cfg;
        end else if (b != sync_cfg[15:8]) begin
          ps_phase = PH_SYNC_HI;
        end
      end
      PH_TYPE_HI: begin
        ps_type  = {b, 8'h00};
        ps_crc   = crc16_byte(ps_crc, b);
        ps_phase = PH_TYPE_LO;
      end
      PH_TYPE_LO: begin
        ps_type[7:0] = b;
        ps_crc       = crc16_byte(ps_crc, b);
        ps_phase     = PH_LENGTH;
      end
      PH_LENGTH: begin
        ps_length = b;
        ps_count  = '0;
        ps_crc    = crc16_byte(ps_crc, b);
        ps_phase  = (b == 0) ? PH_CRC_HI : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        ps_crc           = crc16_byte(ps_crc, b);
        r.result_kind    = KIND_PAYLOAD;
        r.payload_byte   = b;
        r.byte_index     = ps_count;
        r.pkt_type       = ps_type;
        r.payload_length = ps_length;
        due_results.push_back(r);
        ps_count = ps_count + 1'b1;
        if (ps_count >= ps_length) ps_phase = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        ps_crc_hi = b;
        ps_phase  = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        r.result_kind    = KIND_END;
        r.pkt_type       = ps_type;
        r.payload_length = ps_length;
        r.received_crc   = {ps_crc_hi, b};
        r.crc_good       = ({ps_crc_hi, b} == ps_crc);
        due_results.push_back(r);
        ps_phase = PH_SYNC_HI;
      end
      default: ps_phase = PH_SYNC_HI;
    endcase
  endtask

  function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                      input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Build a whole frame at the current register settings: sync, type, length,
  // payload and CRC. A negative fill gives random payload bytes.
  task automatic build_frame(input logic [WORD_W-1:0] ptype, input int unsigned plen,
                             input bit corrupt, input int fill, ref octet_t frame[$]);
    logic [WORD_W-1:0] crc;
    frame = {};
    frame.push_back(sync_cfg[15:8]);
    frame.push_back(sync_cfg[7:0]);
    frame.push_back(ptype[15:8]);
    frame.push_back(ptype[7:0]);
    frame.push_back(octet_t'(plen));
    repeat (plen) frame.push_back((fill < 0) ? octet_t'($urandom) : octet_t'(fill));
    crc = seed_cfg;
    for (int i = 2; i < frame.size(); i++) crc = crc16_byte(crc, frame[i]);
    if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(0, WORD_W - 1));
    frame.push_back(crc[15:8]);
    frame.push_back(crc[7:0]);
  endtask

  task automatic send_frame(ref octet_t frame[$], input int unsigned first,
                            input int unsigned count);
    for (int unsigned i = first; i < first + count; i++) rx_bytes_q.push_back(frame[i]);
  endtask

  // Hold until every byte is in, every item is out, and the pipeline has emptied
  task automatic wait_drained();
    do @(posedge clk);
    while (rx_bytes_q.size() != 0 || bytes_taken != bytes_shown || due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [WORD_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SYNC_WORD) begin
      sync_cfg = val;
    end else if (idx == REG_CRC_SEED) begin
      seed_cfg = val;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed frames with random content, mixed with noise, broken
  // sync attempts and frames cut short
  task automatic random_traffic(input int unsigned budget);
    octet_t            frame[$];
    logic [WORD_W-1:0] ptype;
    int unsigned       sent, r, plen, k;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        k = $urandom_range(1, 4);
        repeat (k) rx_bytes_q.push_back(octet_t'($urandom));
        sent += k;
      end else if (r < 16) begin
        // Sync high byte, once or twice, ahead of whatever follows
        rx_bytes_q.push_back(sync_cfg[15:8]);
        sent++;
        if ($urandom_range(0, 1) == 1) begin
          rx_bytes_q.push_back(sync_cfg[15:8]);
          sent++;
        end
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          plen = 0;
        end else if (r < 85) begin
          plen = $urandom_range(1, 8);
        end else begin
          plen = $urandom_range(9, 40);
        end
        r = $urandom_range(0, 19);
        ptype = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : WORD_W'($urandom);
        build_frame(ptype, plen, $urandom_range(0, 4) == 0, -1, frame);
        // Drop the tail of an occasional frame
        k = ($urandom_range(0, 19) == 0) ? $urandom_range(1, frame.size() - 1) : frame.size();
        send_frame(frame, 0, k);
        sent += k;
      end
    end
  endtask

  // Input accept: feed the model at the edge that takes the item
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      deframe_byte(in_tdata);
      bytes_taken++;
    end
  end

  // Sender: present the next byte once the previous one is taken, with gaps
  always @(negedge clk) begin
    if (bytes_taken == bytes_shown) begin
      if (in_gap_left > 0) begin
        in_gap_left--;
        in_tvalid <= 1'b0;
      end else if (rx_bytes_q.size() > 0) begin
        in_tdata  <= rx_bytes_q.pop_front();
        in_tvalid <= 1'b1;
        bytes_shown++;
        in_gap_left = pick_idle(in_gaps_on);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure stretches when enabled
  always @(negedge clk) begin
    if (out_stall_left > 0) begin
      out_stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (out_stalls_on && $urandom_range(0, 3) == 0) out_stall_left = pick_idle(1'b1);
    end
  end

  // Result check: compare each taken item with the oldest prediction
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected item, expected none, got tuser %h tdata %h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        want = due_results.pop_front();
        check_field("result_kind",    WORD_W'(want.result_kind),    WORD_W'(out_tuser[0]));
        check_field("payload_byte",   WORD_W'(want.payload_byte),   WORD_W'(out_tdata[7:0]));
        check_field("byte_index",     WORD_W'(want.byte_index),     WORD_W'(out_tdata[15:8]));
        check_field("pkt_type",       want.pkt_type,                out_tdata[31:16]);
        check_field("payload_length", WORD_W'(want.payload_length), WORD_W'(out_tdata[39:32]));
        check_field("received_crc",   want.received_crc,            out_tdata[55:40]);
        check_field("crc_good",       WORD_W'(want.crc_good),       WORD_W'(out_tdata[56]));
        check_field("tdata padding",  '0,                           WORD_W'(out_tdata[63:57]));
      end
    end
  end

  // Watchdog: any handshake restarts the count
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    octet_t            frame[$];
    octet_t            hi_byte;
    logic [WORD_W-1:0] new_sync, new_seed;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, reset register values first
    rx_bytes_q.push_back(sync_cfg[15:8]);  // stray byte after sync high drops the hunt
    rx_bytes_q.push_back(8'h00);
    build_frame(16'hFFFF, 0, 1'b0, -1, frame);  // zero length, good CRC
    send_frame(frame, 0, frame.size());
    build_frame(16'h0000, 1, 1'b1, 8'hFF, frame);  // one 0xFF byte, bad CRC
    send_frame(frame, 0, 4);
    // Rewrite both registers with the parser inside the frame; the frame keeps
    // its old seed, the next one picks up the new settings
    wait_drained();
    write_reg(REG_SYNC_WORD, 16'hA35C);
    write_reg(REG_CRC_SEED, 16'h0000);
    write_reg(cfg_idx_t'($urandom_range(REG_FIRST_UNUSED, (1 << CFG_IDX_W) - 1)),
              WORD_W'($urandom));
    send_frame(frame, 4, frame.size() - 4);
    rx_bytes_q.push_back(sync_cfg[15:8]);  // repeated sync high keeps the hunt going
    build_frame(16'h8001, 0, 1'b0, -1, frame);
    send_frame(frame, 0, frame.size());
    wait_drained();

    // Random part over several register settings and idle patterns
    for (int s = 0; s < 6; s++) begin
      hi_byte = octet_t'($urandom);
      new_seed = WORD_W'($urandom);
      case (s)
        0: begin
          new_sync = 16'h0000;
          new_seed = 16'hFFFF;
          in_gaps_on = 1'b0;
          out_stalls_on = 1'b0;
        end
        1: begin
          new_sync = 16'hFFFF;
          new_seed = 16'h0000;
          in_gaps_on = 1'b1;
          out_stalls_on = 1'b1;
        end
        2: begin
          new_sync = {hi_byte, hi_byte ^ octet_t'($urandom_range(1, 255))};
          in_gaps_on = 1'b1;
          out_stalls_on = 1'b0;
        end
        3: begin
          new_sync = {hi_byte, hi_byte ^ octet_t'($urandom_range(1, 255))};
          in_gaps_on = 1'b0;
          out_stalls_on = 1'b1;
        end
        4: begin
          new_sync = {hi_byte, hi_byte};
          in_gaps_on = 1'b1;
          out_stalls_on = 1'b1;
        end
        default: begin
          new_sync = WORD_W'($urandom);
          in_gaps_on = 1'b1;
          out_stalls_on = 1'b1;
        end
      endcase
      write_reg(REG_SYNC_WORD, new_sync);
      write_reg(REG_CRC_SEED, new_seed);
      if (s == 5) begin
        // Longest payload once: index runs up to 254
        build_frame(WORD_W'($urandom), 255, 1'b0, -1, frame);
        send_frame(frame, 0, frame.size());
      end
      // Pause the sender mid-phase until every item is out
      random_traffic(12);
      wait_drained();
      random_traffic(12);
      wait_drained();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
